### sv/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam logic ACT_SPAWN = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RC_SPAWNED  = 2'd0,
        RC_FULL     = 2'd1,
        RC_SWITCHED = 2'd2,
        RC_NO_READY = 2'd3
    } t_code;

    typedef struct packed {
        logic        action;
        logic [31:0] entry_address;
        logic [31:0] saved_context;
    } t_in_item;

    typedef struct packed {
        t_code       result_code;
        logic [3:0]  slot_index;
        logic [31:0] resume_word;
    } t_result;

    // one write address and one read address shared by both stores
    typedef struct packed {
        logic        st_we;
        t_status     st_wdata;
        logic        rs_we;
        logic [31:0] rs_wdata;
        logic        re;
    } t_mem_ctl;

endpackage

### sv/rrts_in_if.sv
`timescale 1ns / 1ps

interface rrts_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] entry_address;
    logic [31:0] saved_context;

    modport source (output valid, output action, output entry_address,
                    output saved_context, input ready);
    modport sink   (input valid, input action, input entry_address,
                    input saved_context, output ready);
endinterface

### sv/rrts_out_if.sv
`timescale 1ns / 1ps

interface rrts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_code;
    logic [3:0]  slot_index;
    logic [31:0] resume_word;

    modport source (output valid, output result_code, output slot_index,
                    output resume_word, input ready);
    modport sink   (input valid, input result_code, input slot_index,
                    input resume_word, output ready);
endinterface

### sv/rrts_slot_store.sv
`timescale 1ns / 1ps

module rrts_slot_store #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrts_pkg::t_mem_ctl            i_ctl,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_waddr,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_raddr,
    output rrts_pkg::t_status             o_st_rdata,
    output logic [31:0]                   o_rs_rdata
);
    import rrts_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);

    t_status             r_st_mem [SLOT_COUNT];
    logic [31:0]         r_rs_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;

    t_status     r_st_q;
    t_status     r_def_q;
    logic        r_hit_q;
    logic [31:0] r_rs_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we) begin
            r_st_mem[i_waddr] <= i_ctl.st_wdata;
        end
        if (i_ctl.re) begin
            r_st_q <= r_st_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rs_we) begin
            r_rs_mem[i_waddr] <= i_ctl.rs_wdata;
        end
        if (i_ctl.re) begin
            r_rs_q <= r_rs_mem[i_raddr];
        end
    end

    // unwritten status entries read as their reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_hit_q <= 1'b0;
            r_def_q <= ST_RUNNING;
        end else begin
            if (i_ctl.st_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_ctl.re) begin
                r_hit_q <= r_vld[i_raddr];
                r_def_q <= (i_raddr == AW'(0)) ? ST_RUNNING : ST_FREE;
            end
        end
    end

    assign o_st_rdata = r_hit_q ? r_st_q : r_def_q;
    assign o_rs_rdata = r_rs_q;

endmodule

### sv/rrts_seq.sv
`timescale 1ns / 1ps

module rrts_seq #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rrts_pkg::t_in_item            i_item,
    output logic                          o_ready,
    output logic                          o_res_valid,
    output rrts_pkg::t_result             o_res,
    input  logic                          i_res_take,
    output rrts_pkg::t_mem_ctl            o_ctl,
    output logic [$clog2(SLOT_COUNT)-1:0] o_waddr,
    output logic [$clog2(SLOT_COUNT)-1:0] o_raddr,
    input  rrts_pkg::t_status             i_st_rdata,
    input  logic [31:0]                   i_rs_rdata
);
    import rrts_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SWAP  = 5'b00100,
        S_FETCH = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state      r_state, n_state;
    logic        r_action, n_action;
    logic [31:0] r_entry, n_entry;
    logic [31:0] r_ctx, n_ctx;
    logic [AW-1:0] r_running, n_running;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW:0]   r_left, n_left;
    logic          r_pend, n_pend;
    logic          r_plast, n_plast;
    logic [AW-1:0] r_paddr, n_paddr;
    logic [AW-1:0] r_pos, n_pos;
    t_result       r_res, n_res;

    logic hit;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(SLOT_COUNT - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [3:0] low_idx(input logic [AW-1:0] a);
        logic [AW+3:0] ext;
        ext = {4'b0000, a};
        return ext[3:0];
    endfunction

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_entry   = r_entry;
        n_ctx     = r_ctx;
        n_running = r_running;
        n_addr    = r_addr;
        n_left    = r_left;
        n_pend    = r_pend;
        n_plast   = r_plast;
        n_paddr   = r_paddr;
        n_pos     = r_pos;
        n_res     = r_res;
        o_ctl     = '0;
        o_ctl.st_wdata = ST_FREE;
        o_waddr   = r_paddr;
        o_raddr   = r_addr;
        o_ready   = 1'b0;
        o_res_valid = 1'b0;
        hit = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_action = i_item.action;
                    n_entry  = i_item.entry_address;
                    n_ctx    = i_item.saved_context;
                    n_pend   = 1'b0;
                    n_plast  = 1'b0;
                    if (i_item.action == ACT_TICK) begin
                        n_addr = wrap_inc(r_running);
                        n_left = (AW + 1)'(SLOT_COUNT - 1);
                    end else begin
                        n_addr = '0;
                        n_left = (AW + 1)'(SLOT_COUNT);
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                hit = r_pend && ((r_action == ACT_TICK) ? (i_st_rdata == ST_READY)
                                                        : (i_st_rdata == ST_FREE));
                if (hit && r_action == ACT_TICK) begin
                    n_pos   = r_paddr;
                    n_state = S_SWAP;
                end else if (hit) begin
                    o_ctl.st_we    = 1'b1;
                    o_ctl.st_wdata = ST_READY;
                    o_ctl.rs_we    = 1'b1;
                    o_ctl.rs_wdata = r_entry;
                    o_waddr        = r_paddr;
                    n_res   = '{RC_SPAWNED, low_idx(r_paddr), 32'd0};
                    n_state = S_DONE;
                end else if (r_pend && r_plast) begin
                    if (r_action == ACT_TICK) begin
                        // nothing else ready: keep running, still save the context
                        o_ctl.rs_we    = 1'b1;
                        o_ctl.rs_wdata = r_ctx;
                        o_waddr        = r_running;
                        n_res = '{RC_NO_READY, low_idx(r_running), 32'd0};
                    end else begin
                        n_res = '{RC_FULL, 4'd0, 32'd0};
                    end
                    n_state = S_DONE;
                end else begin
                    n_pend = r_left != '0;
                    if (r_left != '0) begin
                        o_ctl.re = 1'b1;
                        o_raddr  = r_addr;
                        n_paddr  = r_addr;
                        n_plast  = r_left == (AW + 1)'(1);
                        n_addr   = wrap_inc(r_addr);
                        n_left   = r_left - (AW + 1)'(1);
                    end
                end
            end
            S_SWAP: begin
                o_ctl.st_we    = 1'b1;
                o_ctl.st_wdata = ST_READY;
                o_ctl.rs_we    = 1'b1;
                o_ctl.rs_wdata = r_ctx;
                o_waddr        = r_running;
                o_ctl.re       = 1'b1;
                o_raddr        = r_pos;
                n_state        = S_FETCH;
            end
            S_FETCH: begin
                o_ctl.st_we    = 1'b1;
                o_ctl.st_wdata = ST_RUNNING;
                o_waddr        = r_pos;
                n_running      = r_pos;
                n_res   = '{RC_SWITCHED, low_idx(r_pos), i_rs_rdata};
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= '0;
            r_pend    <= 1'b0;
            r_plast   <= 1'b0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_pend    <= n_pend;
            r_plast   <= n_plast;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_entry  <= n_entry;
        r_ctx    <= n_ctx;
        r_addr   <= n_addr;
        r_paddr  <= n_paddr;
        r_pos    <= n_pos;
        r_res    <= n_res;
    end

    assign o_res = r_res;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("scheduler state not one-hot");

    a_switch_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWAP |-> r_pos != r_running)
        else $error("switch target is the running slot");

    a_fetch_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |=> r_state == S_DONE && r_running == $past(r_pos)
                            && r_res.result_code == RC_SWITCHED)
        else $error("switch not committed");

    a_never_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.st_we |-> o_ctl.st_wdata != ST_FREE)
        else $error("slot status written back to free");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_left <= (AW + 1)'(SLOT_COUNT))
        else $error("scan count out of range");

endmodule

### sv/round_robin_task_slot_scheduler_top.sv
`timescale 1ns / 1ps

// channel   dir  signals                                          accepted when
// i_in      in   action, entry_address, saved_context             valid && ready
// o_out     out  result_code, slot_index, resume_word             valid && ready
//
// one word in, one word out; status is scanned one slot per cycle through
// the status memory, up to every slot for a spawn and up to every slot but
// the running one for a tick; a new word is taken only once the last
// result has passed to the output register
// reset (synchronous, active low): slot 0 running, all other slots free
// the output register holds a result while the next word is taken in

module round_robin_task_slot_scheduler_top #(
    parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rrts_in_if.sink           i_in,
    rrts_out_if.source        o_out
);
    import rrts_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);

    t_in_item      item;
    t_result       res;
    t_mem_ctl      ctl;
    t_status       st_rdata;
    logic [31:0]   rs_rdata;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          seq_ready;
    logic          res_valid;
    logic          take;

    logic    r_out_vld;
    t_result r_out;

    assign item = '{i_in.action, i_in.entry_address, i_in.saved_context};
    assign i_in.ready = seq_ready;

    rrts_slot_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_waddr    (waddr),
        .i_raddr    (raddr),
        .o_st_rdata (st_rdata),
        .o_rs_rdata (rs_rdata)
    );

    rrts_seq #(.SLOT_COUNT(SLOT_COUNT)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_item      (item),
        .o_ready     (seq_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (take),
        .o_ctl       (ctl),
        .o_waddr     (waddr),
        .o_raddr     (raddr),
        .i_st_rdata  (st_rdata),
        .i_rs_rdata  (rs_rdata)
    );

    assign take = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && take) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && take) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.result_code = r_out.result_code;
    assign o_out.slot_index  = r_out.slot_index;
    assign o_out.resume_word = r_out.resume_word;

endmodule
